// ===== src/swm_pkg.sv =====
// Shared constants and types for the sliding window maximum block.
package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int POS_W       = 16;
    localparam int ADDR_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W       = $clog2(WINDOW_MAX + 1);

    // one deque candidate: sample value and its position in the sequence
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] value;
        logic        [POS_W-1:0]       position;
    } cand_t;

    // store access request from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        cand_t             wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

endpackage

// ===== src/sliding_window_maximum.sv =====
// Sliding window maximum: top level with deque sequencer and output register.
//
// Usage:
//   s_ channel carries one sample per item; s_tuser flags the first sample
//   of a new sequence, which empties the window first. Once window_size
//   samples of the sequence have arrived, every item yields one m_ item
//   holding the maximum of the last window_size samples. window_size = 0
//   yields no items; values above 64 act as 64. Write window_size through
//   cfg_wr_en / cfg_wr_data only while idle.
// Flow (s_tready is high only in idle): each item first reads and pops
//   aged-out front candidates, then reads and pops dominated back
//   candidates and pushes the sample; an item with a result then reads
//   the front into the output register, whose m_tvalid rises as the
//   sequencer returns to idle. Deque reads share the one registered read
//   port. Each sample is popped at most once.
// Reset: aresetn low empties the deque, clears position and fill count,
//   drops a pending result and sets window_size to 1. No store clearing.
// Stall: a result waits in the output register while the next item is taken
//   and worked on; the sequencer holds only when it has a new result while
//   the old one is still not taken.
module sliding_window_maximum
    import swm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: window_size
    input  logic        cfg_wr_en,
    input  logic [6:0]  cfg_wr_data,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] sample
    input  logic [0:0]  s_tuser,   // [0] start_req
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] window_max
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRONT_RD,
        ST_FRONT_CMP,
        ST_BACK_RD,
        ST_BACK_CMP,
        ST_PUSH,
        ST_HEAD_RD,
        ST_OUT
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        win_size_reg;
    logic [CNT_W-1:0]        k_reg, k_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [ADDR_W-1:0]       head_reg, head_next;
    logic [CNT_W-1:0]        occ_reg, occ_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic                    out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]  out_data_reg, out_data_next;

    store_req_t              req;
    cand_t                   rd_data;
    logic [POS_W-1:0]        age;
    logic [CNT_W-1:0]        occ_push;
    logic [ADDR_W-1:0]       head_push;
    logic [CNT_W-1:0]        fill_inc;
    logic                    in_fire;

    swm_cand_store u_store (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // distance from the front candidate to the current sample
    assign age = pos_reg - rd_data.position;

    // a full deque after ageing loses its front before the push
    always_comb begin
        if (occ_reg >= CNT_W'(WINDOW_MAX)) begin
            occ_push  = occ_reg - 1'b1;
            head_push = head_reg + 1'b1;
        end else begin
            occ_push  = occ_reg;
            head_push = head_reg;
        end
    end

    assign fill_inc = (fill_reg < CNT_W'(WINDOW_MAX)) ? fill_reg + 1'b1 : fill_reg;

    always_comb begin
        state_next     = state_reg;
        k_next         = k_reg;
        sample_next    = sample_reg;
        head_next      = head_reg;
        occ_next       = occ_reg;
        pos_next       = pos_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        req            = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    sample_next = $signed(s_tdata);
                    k_next      = (win_size_reg > CNT_W'(WINDOW_MAX)) ?
                                  CNT_W'(WINDOW_MAX) : win_size_reg;
                    if (s_tuser[0]) begin
                        head_next = '0;
                        occ_next  = '0;
                        fill_next = '0;
                        pos_next  = '0;
                    end
                    state_next = ST_FRONT_RD;
                end
            end
            ST_FRONT_RD: begin
                if (occ_reg == '0) begin
                    state_next = ST_PUSH;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = head_reg;
                    state_next  = ST_FRONT_CMP;
                end
            end
            ST_FRONT_CMP: begin
                if (age >= POS_W'(k_reg)) begin
                    head_next  = head_reg + 1'b1;
                    occ_next   = occ_reg - 1'b1;
                    state_next = ST_FRONT_RD;
                end else begin
                    state_next = ST_BACK_RD;
                end
            end
            ST_BACK_RD: begin
                if (occ_reg == '0) begin
                    state_next = ST_PUSH;
                end else begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = head_reg + occ_reg[ADDR_W-1:0] - 1'b1;
                    state_next  = ST_BACK_CMP;
                end
            end
            ST_BACK_CMP: begin
                if ($signed(rd_data.value) <= sample_reg) begin
                    occ_next   = occ_reg - 1'b1;
                    state_next = ST_BACK_RD;
                end else begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                req.wr_en            = 1'b1;
                req.wr_addr          = head_push + occ_push[ADDR_W-1:0];
                req.wr_data.value    = sample_reg;
                req.wr_data.position = pos_reg;
                head_next  = head_push;
                occ_next   = occ_push + 1'b1;
                pos_next   = pos_reg + 1'b1;
                fill_next  = fill_inc;
                if (k_reg != '0 && fill_inc >= k_reg) begin
                    state_next = ST_HEAD_RD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_HEAD_RD: begin
                // write landed last cycle, so the front read sees it
                req.rd_en   = 1'b1;
                req.rd_addr = head_reg;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_data.value;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            win_size_reg  <= CNT_W'(1);
            head_reg      <= '0;
            occ_reg       <= '0;
            pos_reg       <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_wr_en) begin
                win_size_reg <= cfg_wr_data;
            end
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            pos_reg       <= pos_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        k_reg        <= k_next;
        sample_reg   <= sample_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== src/swm_cand_store.sv =====
// Candidate store: circular deque storage, one write and one registered read.
module swm_cand_store
    import swm_pkg::*;
(
    input  logic       aclk,
    input  store_req_t req,
    output cand_t      rd_data
);

    cand_t mem [WINDOW_MAX];
    cand_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
